[rtl/skce_pkg.sv]
`default_nettype none

package skce_pkg;

  // Width of the canonical k-mer result port (2 bits per base, 32 bases).
  localparam int OUT_W     = 64;
  localparam int BYTE_W    = 8;
  localparam int KLEN_W    = 6;
  localparam int SYMS_W    = 8;
  localparam int KBYTES_W  = 4;
  localparam int BASES_PER_BYTE = 4;

  // Parser phase of the record stream.
  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_KMER  = 2'd1,
    PH_SYMS  = 2'd2
  } phase_t;

  // One byte's worth of work for the back end.
  typedef struct packed {
    logic [BYTE_W-1:0] data;        // packed bases, first base in bits 7:6
    logic              clr;         // count byte: clear both k-mers
    logic [2:0]        nshift;      // bases to shift in, 0 to 4
    logic              emit;        // this byte produces results
    logic [1:0]        first_emit;  // first base position that produces a result
    logic              rec_end;     // the last result closes the record
  } cmd_t;

endpackage

`default_nettype wire

[rtl/skce_fifo.sv]
`default_nettype none

module skce_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic     [W-1:0]  rdata,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/skce_front.sv]
`default_nettype none

module skce_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [skce_pkg::KLEN_W-1:0]   keff,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [skce_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                          in_bin_start,
  output logic                               cmd_push,
  output skce_pkg::cmd_t                     cmd,
  input  wire logic                          q_full
);

  import skce_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [SYMS_W-1:0]   syms_r, syms_nxt;
  logic [KBYTES_W-1:0] kbl_r, kbl_nxt;

  phase_t              ph;
  logic                accept;
  logic                kmer_last;
  logic [2:0]          nb;
  logic [2:0]          avail;
  logic [2:0]          extra;
  logic [SYMS_W-1:0]   syms_left;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Effective phase for this byte, and how many extra bases it carries.
  always_comb begin
    if (in_bin_start) begin
      ph = PH_COUNT;
    end else begin
      case (phase_r)
        PH_KMER: ph = PH_KMER;
        PH_SYMS: ph = PH_SYMS;
        default: ph = PH_COUNT;
      endcase
    end
    kmer_last = (kbl_r <= KBYTES_W'(1));
    nb        = {1'b0, keff[1:0] - 2'd1} + 3'd1;
    avail     = (ph == PH_KMER) ? 3'(BASES_PER_BYTE) - nb : 3'(BASES_PER_BYTE);
    extra     = (syms_r < SYMS_W'(avail)) ? syms_r[2:0] : avail;
    syms_left = syms_r - SYMS_W'(extra);
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    syms_nxt  = syms_r;
    kbl_nxt   = kbl_r;
    case (ph)
      PH_COUNT: begin
        syms_nxt  = in_byte;
        kbl_nxt   = KBYTES_W'((7'(keff) + 7'd3) >> 2);
        phase_nxt = PH_KMER;
      end
      PH_KMER: begin
        if (!kmer_last) begin
          kbl_nxt   = kbl_r - 1'b1;
          phase_nxt = PH_KMER;
        end else begin
          kbl_nxt   = '0;
          syms_nxt  = syms_left;
          phase_nxt = (syms_left == '0) ? PH_COUNT : PH_SYMS;
        end
      end
      PH_SYMS: begin
        syms_nxt  = syms_left;
        phase_nxt = (syms_left == '0) ? PH_COUNT : PH_SYMS;
      end
      default: phase_nxt = PH_COUNT;
    endcase
  end

  // Command for the back end.
  always_comb begin
    cmd.data       = in_byte;
    cmd.clr        = 1'b0;
    cmd.nshift     = '0;
    cmd.emit       = 1'b0;
    cmd.first_emit = '0;
    cmd.rec_end    = (syms_left == '0);
    case (ph)
      PH_COUNT: begin
        cmd.clr = 1'b1;
      end
      PH_KMER: begin
        if (!kmer_last) begin
          cmd.nshift = 3'(BASES_PER_BYTE);
        end else begin
          cmd.nshift     = nb + extra;
          cmd.emit       = 1'b1;
          cmd.first_emit = 2'(nb - 3'd1);
        end
      end
      PH_SYMS: begin
        cmd.nshift = extra;
        cmd.emit   = (extra != '0);
      end
      default: cmd.clr = 1'b1;
    endcase
    // A symbol byte past the end of a record changes nothing downstream.
    cmd_push = accept && (cmd.clr || cmd.nshift != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      syms_r  <= '0;
      kbl_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      syms_r  <= syms_nxt;
      kbl_r   <= kbl_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/skce_back.sv]
`default_nettype none

module skce_back #(
  parameter int MAX_K = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [skce_pkg::KLEN_W-1:0]  keff,
  input  wire skce_pkg::cmd_t               cmd,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [skce_pkg::OUT_W-1:0]        out_canonical_kmer,
  output logic                              out_record_end,
  output logic                              out_last_of_byte
);

  import skce_pkg::*;

  localparam int KW = 2 * MAX_K;

  logic [KW-1:0] fwd_r, fwd_nxt;
  logic [KW-1:0] rev_r, rev_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [KW-1:0] kmin_r;
  logic          rec_end_r;
  logic          last_r;

  logic [KW-1:0] mask;
  logic [KW-1:0] rev_sh;
  logic [1:0]    base;
  logic          emit_now;
  logic          last_step;
  logic          out_free;
  logic          go;

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = (KLEN_W'(i) < keff) ? 2'b11 : 2'b00;
    end
  end

  always_comb begin
    case (pos_r)
      2'd0:    base = cmd.data[7:6];
      2'd1:    base = cmd.data[5:4];
      2'd2:    base = cmd.data[3:2];
      2'd3:    base = cmd.data[1:0];
      default: base = cmd.data[7:6];
    endcase
  end

  // One base step: forward takes the base at the low end, reverse ORs its
  // complement into base slot K-1. That slot may still hold bits when K has
  // shrunk since the previous step.
  always_comb begin
    rev_sh = rev_r >> 2;
    for (int i = 0; i < MAX_K; i++) begin
      if (KLEN_W'(i) == keff - 1'b1) begin
        rev_sh[2*i +: 2] = rev_sh[2*i +: 2] | ~base;
      end
    end
    fwd_nxt = ((fwd_r << 2) | KW'(base)) & mask;
    rev_nxt = rev_sh & mask;
  end

  assign emit_now  = !cmd.clr && cmd.emit && (pos_r >= cmd.first_emit);
  assign last_step = cmd.clr || ({1'b0, pos_r} == cmd.nshift - 3'd1);
  assign out_free  = !out_valid_r || !out_stall;
  assign go        = !q_empty && (!emit_now || out_free);
  assign q_pop     = go && last_step;

  always_comb begin
    pos_nxt = pos_r;
    if (go) begin
      pos_nxt = last_step ? 2'd0 : pos_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (go && emit_now) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= '0;
      rev_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) begin
        fwd_r <= cmd.clr ? '0 : fwd_nxt;
        rev_r <= cmd.clr ? '0 : rev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_now) begin
      kmin_r    <= (fwd_nxt < rev_nxt) ? fwd_nxt : rev_nxt;
      rec_end_r <= last_step && cmd.rec_end;
      last_r    <= last_step;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_canonical_kmer = OUT_W'(kmin_r);
  assign out_record_end     = rec_end_r;
  assign out_last_of_byte   = last_r;

endmodule

`default_nettype wire

[rtl/superkmer_expand_canonical.sv]
`default_nettype none

// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_stall    in_byte, in_bin_start
// out      output     out_valid/out_stall  out_canonical_kmer, out_record_end,
//                                          out_last_of_byte
// cfg      input      cfg_valid/cfg_ready  cfg_kmer_len
//
// The back end shifts one base per cycle and results leave at one per cycle
// while the output is not stalled; a k-mer or symbol byte shifts up to four
// bases. A two-entry command queue sits between parser and shifter, and the
// result register lets the shifter run while a result waits.
// Reset is synchronous and active low; it returns K to 31 and clears state.
// A stall on the output holds only the steps that produce results.

module superkmer_expand_canonical #(
  parameter int MAX_K = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [skce_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                         in_bin_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [skce_pkg::OUT_W-1:0]        out_canonical_kmer,
  output logic                              out_record_end,
  output logic                              out_last_of_byte,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [skce_pkg::KLEN_W-1:0]  cfg_kmer_len
);

  import skce_pkg::*;

  localparam int QDEPTH = 2;

  logic [KLEN_W-1:0] kmer_len_r;
  logic [KLEN_W-1:0] keff;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // The register is always writable; the user must keep writes to idle times.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KLEN_W'(31);
    end else if (cfg_valid && cfg_ready) begin
      kmer_len_r <= cfg_kmer_len;
    end
  end

  // The working k-mer length is the register clamped to one through MAX_K.
  always_comb begin
    if (kmer_len_r == '0) begin
      keff = KLEN_W'(1);
    end else if (kmer_len_r > KLEN_W'(MAX_K)) begin
      keff = KLEN_W'(MAX_K);
    end else begin
      keff = kmer_len_r;
    end
  end

  // The parser turns each accepted byte into at most one back-end command.
  skce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .keff         (keff),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_bin_start (in_bin_start),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .q_full       (q_full)
  );

  skce_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (q_pop),
    .rdata (cmd_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // The shifter keeps both k-mers and registers the smaller one per result.
  skce_back #(
    .MAX_K (MAX_K)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .keff               (keff),
    .cmd                (cmd_head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_canonical_kmer (out_canonical_kmer),
    .out_record_end     (out_record_end),
    .out_last_of_byte   (out_last_of_byte)
  );

endmodule

`default_nettype wire

[tb/sv/tb_superkmer_expand_canonical.sv]
`default_nettype none

// Self-checking testbench for the super-k-mer expander.
//
// Bytes of packed super-k-mer records go in on the in channel; every accepted
// byte is also handed to a software copy of the parser and the two k-mer shift
// registers, which pushes the canonical k-mers that byte must produce onto a
// queue. A receiver process pops the oldest queued k-mer for every beat that
// leaves on the out channel and compares the three result fields one by one.
//
// Both sides draw a random wait per beat, and the random section switches
// either side into a burst mode now and then so that stretches without any
// gaps occur as well. The k-mer length is only changed while the block is
// drained, which includes pauses in the middle of a record.
module tb_superkmer_expand_canonical;
  import skce_pkg::*;

  localparam int KMAX = 32;
  // Cycles allowed after the last expected k-mer before the block counts as
  // idle; they cover the queued commands and the result register.
  localparam int DRAIN_CYCLES = 32;
  // Cycles in a row without any accepted beat before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BYTES = 78;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [OUT_W-1:0] kmer;
    logic             rec_end;
    logic             last;
  } canon_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               in_bin_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   out_canonical_kmer;
  logic               out_record_end;
  logic               out_last_of_byte;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [KLEN_W-1:0]  cfg_kmer_len = '0;

  superkmer_expand_canonical #(.MAX_K(KMAX)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_bin_start       (in_bin_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_canonical_kmer (out_canonical_kmer),
    .out_record_end     (out_record_end),
    .out_last_of_byte   (out_last_of_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_kmer_len       (cfg_kmer_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Software copy of the block state.
  logic [OUT_W-1:0]    fwd_kmer;
  logic [OUT_W-1:0]    rc_kmer;
  phase_t              prs_phase;
  logic [SYMS_W-1:0]   syms_left;
  logic [KBYTES_W-1:0] kbytes_left;
  logic [KLEN_W-1:0]   k_setting;

  canon_t expected_kmers[$];

  int  errors = 0;
  int  results_seen = 0;
  int  sent_bytes = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void reset_model();
    fwd_kmer    = '0;
    rc_kmer     = '0;
    prs_phase   = PH_COUNT;
    syms_left   = '0;
    kbytes_left = '0;
    k_setting   = KLEN_W'(31);
  endfunction

  // The register is six bits wide, but the block clamps K to 1..KMAX.
  function automatic int unsigned active_k();
    int unsigned k;
    k = k_setting;
    if (k < 1) k = 1;
    if (k > KMAX) k = KMAX;
    return k;
  endfunction

  // At K equal to 32 the whole 64-bit word is the k-mer.
  function automatic logic [OUT_W-1:0] base_mask(int unsigned k);
    if (k >= 32) return '1;
    return (64'd1 << (2 * k)) - 64'd1;
  endfunction

  // A new base enters the forward k-mer at the low end and, complemented,
  // the reverse-complement k-mer at the high end.
  function automatic void push_base(int unsigned k, logic [1:0] s);
    logic [OUT_W-1:0] m;
    m = base_mask(k);
    fwd_kmer = ((fwd_kmer << 2) | {62'd0, s}) & m;
    rc_kmer  = ((rc_kmer >> 2) | ({62'd0, ~s} << (2 * k - 2))) & m;
  endfunction

  function automatic canon_t current_canon(logic rec_end);
    canon_t c;
    c.kmer    = (fwd_kmer < rc_kmer) ? fwd_kmer : rc_kmer;
    c.rec_end = rec_end;
    c.last    = 1'b0;
    return c;
  endfunction

  // Advances the model by one accepted byte and queues the k-mers it yields.
  function automatic void predict_byte(logic [BYTE_W-1:0] b, logic st);
    int unsigned k;
    int unsigned j;
    int unsigned nb;
    int          n;
    canon_t      res[BASES_PER_BYTE];
    k = active_k();
    j = 0;
    n = 0;
    if (st) prs_phase = PH_COUNT;
    if (prs_phase == PH_COUNT) begin
      // A count byte clears both k-mers and fixes how many k-mer bytes follow.
      syms_left   = b;
      kbytes_left = KBYTES_W'((k + 3) / 4);
      fwd_kmer    = '0;
      rc_kmer     = '0;
      prs_phase   = PH_KMER;
      return;
    end
    if (prs_phase == PH_KMER) begin
      if (kbytes_left > 1) begin
        for (j = 0; j < 4; j++) push_base(k, 2'(b >> (6 - 2 * j)));
        kbytes_left--;
        return;
      end
      // The last k-mer byte completes the first k-mer; any bases left in it
      // are already extra symbols.
      kbytes_left = '0;
      nb = ((k - 1) & 3) + 1;
      for (j = 0; j < nb; j++) push_base(k, 2'(b >> (6 - 2 * j)));
      res[n] = current_canon(syms_left == 0);
      n++;
    end
    // Bases after the last extra symbol of the record are padding.
    for (; j < 4 && syms_left > 0; j++) begin
      push_base(k, 2'(b >> (6 - 2 * j)));
      syms_left--;
      res[n] = current_canon(syms_left == 0);
      n++;
    end
    prs_phase = (syms_left == 0) ? PH_COUNT : PH_SYMS;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      expected_kmers.insert(expected_kmers.size(), res[i]);
    end
  endfunction

  // One beat on the in channel. The byte goes to the model when the block
  // takes it, so the expected k-mers are queued before any of them can leave.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_bin_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, st);
    sent_bytes++;
  endtask

  // A whole record for the current K: count byte, then every byte needed for
  // K plus count bases. A negative fill draws each byte at random.
  task automatic send_record(input int unsigned count, input int fill, input logic st);
    int unsigned nbytes;
    nbytes = (active_k() + count + 3) / 4;
    send_byte(BYTE_W'(count), st);
    for (int unsigned i = 0; i < nbytes; i++) begin
      send_byte((fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill), 1'b0);
    end
  endtask

  // Bytes that yield no k-mer leave no trace in the queue, so after it empties
  // the block may still be shifting; the extra cycles cover that.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_kmers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_klen(input logic [KLEN_W-1:0] v);
    wait_idle();
    cfg_valid    <= 1'b1;
    cfg_kmer_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    k_setting = v;
  endtask

  // Receiver: random stall after every beat, plus the result check.
  int unsigned rx_hold = 0;
  canon_t      head;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_kmers.size() == 0) begin
        flag_error($sformatf("k-mer beat %0d arrived with nothing expected: %h",
                             results_seen, out_canonical_kmer));
      end else begin
        head = expected_kmers.pop_front();
        if (out_canonical_kmer !== head.kmer)
          flag_error($sformatf("beat %0d canonical_kmer: expected %h, got %h",
                               results_seen, head.kmer, out_canonical_kmer));
        if (out_record_end !== head.rec_end)
          flag_error($sformatf("beat %0d record_end: expected %b, got %b",
                               results_seen, head.rec_end, out_record_end));
        if (out_last_of_byte !== head.last)
          flag_error($sformatf("beat %0d last_of_byte: expected %b, got %b",
                               results_seen, head.last, out_last_of_byte));
      end
      rx_hold = rx_burst ? 0 : $urandom_range(0, 4);
      out_stall <= (rx_hold != 0);
    end else if (rx_hold > 1) begin
      rx_hold--;
    end else if (rx_hold == 1) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog on forward progress of any of the three channels.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // K at its reset value of 31: the last k-mer byte holds three k-mer bases
  // and one extra symbol.
  task automatic test_default_k();
    send_record(1, -1, 1'b1);
  endtask

  // Clamping at both ends of the register range, K equal to 32 with an
  // all-ones k-mer, and a multiple of four with padding in the last byte.
  task automatic test_k_extremes();
    set_klen(KLEN_W'(0));
    send_record(3, 8'h00, 1'b1);
    set_klen(KLEN_W'(63));
    send_record(0, 8'hFF, 1'b0);
    set_klen(KLEN_W'(4));
    send_record(5, -1, 1'b1);
  endtask

  // A start flag in the middle of a record throws the rest of it away.
  task automatic test_resync();
    send_byte(BYTE_W'(9), 1'b1);
    send_byte(BYTE_W'($urandom), 1'b0);
    send_record(0, -1, 1'b1);
  endtask

  // K changes after the first k-mer byte; the k-mer byte count stays as set
  // by the count byte, while the shifts use the new K.
  task automatic test_k_change_midrecord();
    set_klen(KLEN_W'(5));
    send_byte(BYTE_W'(2), 1'b1);
    send_byte(BYTE_W'($urandom), 1'b0);
    set_klen(KLEN_W'(2));
    send_byte(BYTE_W'($urandom), 1'b0);
    send_byte(BYTE_W'($urandom), 1'b0);
  endtask

  function automatic logic [KLEN_W-1:0] pick_klen();
    case ($urandom_range(0, 7))
      0:       return KLEN_W'(1);
      1:       return KLEN_W'(KMAX);
      2:       return KLEN_W'(0);
      3:       return KLEN_W'(63);
      default: return KLEN_W'($urandom_range(1, KMAX));
    endcase
  endfunction

  // Mostly well-formed records with random content, some cut short by a new
  // start flag, and a little noise. A start flag is optional only when the
  // parser already waits for a count byte.
  task automatic test_random_records();
    int          start_bytes;
    int unsigned pick;
    int unsigned nbytes;
    logic        st;
    start_bytes = sent_bytes;
    // One long record first so that the high bits of the count byte are used.
    set_klen(KLEN_W'($urandom_range(1, 8)));
    send_record($urandom_range(128, 255), -1, 1'b1);
    while (sent_bytes - start_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 3) == 0) rx_burst = ~rx_burst;
      if ($urandom_range(0, 4) == 0) set_klen(pick_klen());
      st = (prs_phase == PH_COUNT) ? 1'($urandom_range(0, 1)) : 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_record($urandom_range(0, 12), -1, st);
      end else if (pick == 8) begin
        nbytes = (active_k() + 3) / 4;
        send_byte(BYTE_W'($urandom_range(1, 12)), st);
        repeat ($urandom_range(0, nbytes)) send_byte(BYTE_W'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3))
          send_byte(BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_k();
    test_k_extremes();
    test_resync();
    test_k_change_midrecord();
    test_random_records();

    wait_idle();
    if (expected_kmers.size() != 0)
      flag_error($sformatf("%0d expected k-mers never arrived", expected_kmers.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[superkmer_expand_canonical.f]
rtl/skce_pkg.sv
rtl/skce_fifo.sv
rtl/skce_front.sv
rtl/skce_back.sv
rtl/superkmer_expand_canonical.sv
tb/sv/tb_superkmer_expand_canonical.sv
